// ----- hw/rtl/pfnd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnd_pkg
// Shared types and constants for the fractional-N divider calculator.
// ----------------------------------------------------------------------------
package pfnd_pkg;

    // Field widths
    localparam int REQ_W   = 33;
    localparam int RDIV_W  = 8;
    localparam int MOD_W   = 12;
    localparam int FREF_W  = 28;
    localparam int INT_W   = 16;
    localparam int CODE_W  = 3;
    localparam int DVD_W   = 57;   // widest dividend: (INT*MOD+FRAC)*Fref
    localparam int CFG_IDX_W = 2;

    // Limits
    localparam logic [REQ_W-1:0]  LOW_LIMIT_HZ  = 33'd34000000;
    localparam logic [REQ_W-1:0]  HIGH_LIMIT_HZ = 33'd4500000000;
    localparam logic [REQ_W-1:0]  VCO_MIN_HZ    = 33'd2200000000;
    localparam logic [CODE_W-1:0] MAX_DIV_CODE  = 3'd6;
    localparam logic [INT_W-1:0]  INT_MAX_VAL   = 16'hFFFF;

    // Register reset values
    localparam logic [RDIV_W-1:0] RDIV_RST = 8'd1;
    localparam logic [MOD_W-1:0]  MOD_RST  = 12'd4095;
    localparam logic [FREF_W-1:0] FREF_RST = 28'd25000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_DIVIDER = 2'd0,
        CFG_MODULUS     = 2'd1,
        CFG_REF_FREQ    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LOW  = 2'd1,
        ST_HIGH = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DOUBLE,
        OP_MUL_NUM,
        OP_DIV_INT,
        OP_MUL_FRAC,
        OP_DIV_FRAC,
        OP_MUL_ACT1,
        OP_MUL_ACT2,
        OP_DIV_ACT,
        OP_FINISH,
        OP_REJECT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_INT,
        S_WAIT_INT,
        S_DIV_FRAC,
        S_WAIT_FRAC,
        S_ACT2,
        S_DIV_ACT,
        S_WAIT_ACT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic vco_ok;
        logic div_busy;
        logic out_busy;
    } t_stat;

endpackage

// ----- hw/rtl/pll_frac_n_divider_calc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_frac_n_divider_calc_core
// Computes INT, FRAC, output divider code and achieved frequency of a
// fractional-N synthesizer for a requested output frequency.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   40     req_hz[32:0]
//  m_axis    out  72     status, int_value, frac_value, div_code,
//                        div_changed, actual_hz
//  cfg       in   2+28   register index, write data
//
//  An in-range request passes through one load step, k doubling steps (k =
//  0..7 doublings), one multiply step, three passes of the shared 57-step
//  bit-serial divider with one multiply step before the second pass and two
//  before the third, and then loads its result.
//  Out-of-range requests go from the range check straight to the result.
//  Synchronous active-low reset; no clearing pass.
//  A new request is taken while the previous result waits in the output
//  register; the block holds before loading a result while that register
//  is still full.
// ----------------------------------------------------------------------------
module pll_frac_n_divider_calc_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // req_hz[32:0], zeros [39:33]
    input  logic [39:0]                       s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // status[1:0], int_value[17:2], frac_value[29:18], div_code[32:30],
    // div_changed[33], actual_hz[66:34], zeros [71:67]
    output logic [71:0]                       m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pfnd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pfnd_pkg::FREF_W-1:0]       i_cfg_data
);
    import pfnd_pkg::*;

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [1:0]        w_status;
    logic [INT_W-1:0]  w_int;
    logic [MOD_W-1:0]  w_frac;
    logic [CODE_W-1:0] w_code;
    logic              w_chg;
    logic [REQ_W-1:0]  w_act;

    assign o_cfg_ready = 1'b1;

    pfnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pfnd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_hz      (s_axis_tdata[REQ_W-1:0]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (w_status),
        .o_int_value   (w_int),
        .o_frac_value  (w_frac),
        .o_div_code    (w_code),
        .o_div_changed (w_chg),
        .o_actual_hz   (w_act)
    );

    assign m_axis_tdata = {5'b0, w_act, w_chg, w_code, w_frac, w_int, w_status};

endmodule

// ----- hw/rtl/pfnd_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnd_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfnd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pfnd_pkg::DVD_W-1:0]    i_dividend,
    input  logic [pfnd_pkg::FREF_W-1:0]   i_divisor,
    output logic                          o_busy,
    output logic [pfnd_pkg::DVD_W-1:0]    o_quot,
    output logic [pfnd_pkg::FREF_W-1:0]   o_rem
);
    import pfnd_pkg::*;

    localparam logic [5:0] STEPS = 6'(DVD_W);

    logic               r_busy, n_busy;
    logic [5:0]         r_cnt, n_cnt;
    logic [DVD_W-1:0]   r_q, n_q;
    logic [FREF_W-1:0]  r_rem, n_rem;
    logic [FREF_W-1:0]  r_div, n_div;
    logic [FREF_W:0]    w_trial;
    logic [FREF_W:0]    w_diff;

    // one shift-subtract step
    always_comb begin
        w_trial = {r_rem, r_q[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEPS;
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_diff[FREF_W-1:0];
                n_q   = {r_q[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[FREF_W-1:0];
                n_q   = {r_q[DVD_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 6'd1;
            n_busy = (r_cnt != 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    // remainder ends below the divisor
    a_rem_lt_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    // step counter stays in range while busy
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != 6'd0 && r_cnt <= STEPS))
        else $error("divider step count out of range");

endmodule

// ----- hw/rtl/pfnd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnd_dp
// Datapath: config registers, operand registers, multipliers, result register.
// ----------------------------------------------------------------------------
module pfnd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfnd_pkg::t_cmd                    i_cmd,
    output pfnd_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_we,
    input  logic [pfnd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pfnd_pkg::FREF_W-1:0]       i_cfg_data,
    input  logic [pfnd_pkg::REQ_W-1:0]        i_req_hz,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [pfnd_pkg::INT_W-1:0]        o_int_value,
    output logic [pfnd_pkg::MOD_W-1:0]        o_frac_value,
    output logic [pfnd_pkg::CODE_W-1:0]       o_div_code,
    output logic                              o_div_changed,
    output logic [pfnd_pkg::REQ_W-1:0]        o_actual_hz
);
    import pfnd_pkg::*;

    // config registers
    logic [RDIV_W-1:0] r_rdiv;
    logic [MOD_W-1:0]  r_mod;
    logic [FREF_W-1:0] r_fref;
    logic [RDIV_W-1:0] w_r;
    logic [MOD_W-1:0]  w_m;
    logic [FREF_W-1:0] w_f;

    // working registers
    logic [REQ_W-1:0]  r_vco;
    logic [CODE_W-1:0] r_k;
    t_status           r_stat;
    logic [DVD_W-1:0]  r_dvd;
    logic [FREF_W-1:0] r_den;
    logic [INT_W-1:0]  r_iv;
    logic              r_sat;
    logic [MOD_W-1:0]  r_fv;
    logic [28:0]       r_s;
    logic [CODE_W-1:0] r_last;

    // result register
    logic              r_out_valid;
    t_status           r_o_status;
    logic [INT_W-1:0]  r_o_int;
    logic [MOD_W-1:0]  r_o_frac;
    logic [CODE_W-1:0] r_o_code;
    logic              r_o_chg;
    logic [REQ_W-1:0]  r_o_act;

    logic              w_div_start;
    logic              w_div_busy;
    logic [DVD_W-1:0]  w_quot;
    logic [FREF_W-1:0] w_rem;

    logic [40:0]       w_num;
    logic [39:0]       w_frac_prod;
    logic [MOD_W-1:0]  w_fv;
    logic [28:0]       w_s;
    logic [19:0]       w_rm;
    logic [26:0]       w_den;
    logic [DVD_W-1:0]  w_act_prod;
    logic              w_q_sat;
    logic [CODE_W-1:0] w_code;
    t_status           w_chk;

    // zero settings act as one
    assign w_r = (r_rdiv == '0) ? RDIV_W'(1) : r_rdiv;
    assign w_m = (r_mod  == '0) ? MOD_W'(1)  : r_mod;
    assign w_f = (r_fref == '0) ? FREF_W'(1) : r_fref;

    // range check of incoming request
    always_comb begin
        priority if (i_req_hz < LOW_LIMIT_HZ)  w_chk = ST_LOW;
        else if (i_req_hz > HIGH_LIMIT_HZ)     w_chk = ST_HIGH;
        else                                   w_chk = ST_OK;
    end

    // arithmetic for the multiply ops
    assign w_num       = 41'(r_vco) * 41'(w_r);
    assign w_q_sat     = (w_quot[DVD_W-1:INT_W] != '0);
    assign w_frac_prod = 40'(w_rem) * 40'(w_m);
    assign w_fv        = r_sat ? (w_m - MOD_W'(1)) : w_quot[MOD_W-1:0];
    assign w_s         = 29'(29'(r_iv) * 29'(w_m)) + 29'(w_fv);
    assign w_rm        = 20'(w_r) * 20'(w_m);
    assign w_den       = 27'(w_rm) << r_k;
    assign w_act_prod  = 57'(r_s) * 57'(w_f);
    assign w_code      = (r_k > MAX_DIV_CODE) ? MAX_DIV_CODE : r_k;
    assign w_div_start = (i_cmd.op == OP_DIV_INT) || (i_cmd.op == OP_DIV_FRAC)
                      || (i_cmd.op == OP_DIV_ACT);

    pfnd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_den),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdiv <= RDIV_RST;
            r_mod  <= MOD_RST;
            r_fref <= FREF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REF_DIVIDER: r_rdiv <= i_cfg_data[RDIV_W-1:0];
                CFG_MODULUS:     r_mod  <= i_cfg_data[MOD_W-1:0];
                CFG_REF_FREQ:    r_fref <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand sequencing
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_vco  <= i_req_hz;
                r_k    <= '0;
                r_stat <= w_chk;
            end
            OP_DOUBLE: begin
                r_vco <= {r_vco[REQ_W-2:0], 1'b0};
                r_k   <= r_k + CODE_W'(1);
            end
            OP_MUL_NUM: begin
                r_dvd <= DVD_W'(w_num);
                r_den <= w_f;
            end
            OP_MUL_FRAC: begin
                r_sat <= w_q_sat;
                r_iv  <= w_q_sat ? INT_MAX_VAL : w_quot[INT_W-1:0];
                r_dvd <= DVD_W'(w_frac_prod);
            end
            OP_MUL_ACT1: begin
                r_fv  <= w_fv;
                r_s   <= w_s;
                r_den <= FREF_W'(w_den);
            end
            OP_MUL_ACT2: r_dvd <= w_act_prod;
            default: ;
        endcase
    end

    // stored divider code and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= MAX_DIV_CODE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_FINISH) begin
                r_last <= w_code;
            end
            if ((i_cmd.op == OP_FINISH) || (i_cmd.op == OP_REJECT)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.op == OP_FINISH) begin
            r_o_status <= ST_OK;
            r_o_int    <= r_iv;
            r_o_frac   <= r_fv;
            r_o_code   <= w_code;
            r_o_chg    <= (w_code != r_last);
            r_o_act    <= w_quot[REQ_W-1:0];
        end else if (i_cmd.op == OP_REJECT) begin
            r_o_status <= r_stat;
            r_o_int    <= '0;
            r_o_frac   <= '0;
            r_o_code   <= '0;
            r_o_chg    <= 1'b0;
            r_o_act    <= '0;
        end
    end

    assign o_stat.reject   = (r_stat != ST_OK);
    assign o_stat.vco_ok   = (r_vco >= VCO_MIN_HZ);
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_int_value   = r_o_int;
    assign o_frac_value  = r_o_frac;
    assign o_div_code    = r_o_code;
    assign o_div_changed = r_o_chg;
    assign o_actual_hz   = r_o_act;

    // rejected results carry no settings
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status != ST_OK) |->
            (r_o_int == '0 && r_o_frac == '0 && r_o_act == '0 && !r_o_chg))
        else $error("rejected result has nonzero fields");

    // accepted result has FRAC below the modulus and a legal code
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status == ST_OK) |->
            (r_o_frac < w_m && r_o_code <= MAX_DIV_CODE))
        else $error("FRAC or divider code out of range");

endmodule

// ----- hw/rtl/pfnd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfnd_ctrl
// Sequencer: steps the datapath through check, normalize, and three divides.
// ----------------------------------------------------------------------------
module pfnd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pfnd_pkg::t_stat  i_stat,
    output pfnd_pkg::t_cmd   o_cmd
);
    import pfnd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.reject) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.op = OP_REJECT;
                        n_state  = S_IDLE;
                    end
                end else if (!i_stat.vco_ok) begin
                    o_cmd.op = OP_DOUBLE;
                end else begin
                    o_cmd.op = OP_MUL_NUM;
                    n_state  = S_DIV_INT;
                end
            end
            S_DIV_INT: begin
                o_cmd.op = OP_DIV_INT;
                n_state  = S_WAIT_INT;
            end
            S_WAIT_INT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_MUL_FRAC;
                    n_state  = S_DIV_FRAC;
                end
            end
            S_DIV_FRAC: begin
                o_cmd.op = OP_DIV_FRAC;
                n_state  = S_WAIT_FRAC;
            end
            S_WAIT_FRAC: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_MUL_ACT1;
                    n_state  = S_ACT2;
                end
            end
            S_ACT2: begin
                o_cmd.op = OP_MUL_ACT2;
                n_state  = S_DIV_ACT;
            end
            S_DIV_ACT: begin
                o_cmd.op = OP_DIV_ACT;
                n_state  = S_WAIT_ACT;
            end
            S_WAIT_ACT: begin
                if (!i_stat.div_busy && !i_stat.out_busy) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // the divider is never restarted while a divide runs
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT_INT || r_state == S_WAIT_FRAC || r_state == S_WAIT_ACT)
            && i_stat.div_busy |=> (r_state == $past(r_state)))
        else $error("sequencer left a wait state during a divide");

endmodule
